// File: hdl/lcg_xc_pkg.sv
package lcg_xc_pkg;

	localparam int KEY_W     = 31;            // keystream word and register width
	localparam int PROD_W    = 2 * KEY_W;     // a*x + c always fits here
	localparam int ALU_W     = PROD_W + 1;    // shared adder width
	localparam int DIV_W     = KEY_W + 1;     // divisor, modulus zero means 2^31
	localparam int MUL_STEPS = KEY_W;         // one multiplier bit per cycle
	localparam int DIV_STEPS = PROD_W;        // one dividend bit per cycle
	localparam int CNT_W     = 6;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MULTIPLIER = 3'd0,
		REG_INCREMENT  = 3'd1,
		REG_MODULUS    = 3'd2,
		REG_SEED_VALUE = 3'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] plain_byte;
		logic       start_of_message;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] cipher_byte;
		logic       end_of_message;
	} out_item_t;

	// status of the next-word unit
	typedef struct packed {
		logic busy;
		logic done;
	} step_stat_t;

endpackage

// File: hdl/lcg_xc_addsub.sv
module lcg_xc_addsub (
	input  logic [lcg_xc_pkg::ALU_W-1:0] op_a,
	input  logic [lcg_xc_pkg::ALU_W-1:0] op_b,
	input  logic                         sub,
	output logic [lcg_xc_pkg::ALU_W-1:0] sum,
	output logic                         cout
);

	logic [lcg_xc_pkg::ALU_W-1:0] b_eff;

	assign b_eff = sub ? ~op_b : op_b;
	assign {cout, sum} = {1'b0, op_a} + {1'b0, b_eff} + (lcg_xc_pkg::ALU_W + 1)'(sub);

endmodule

// File: hdl/lcg_xc_step.sv
module lcg_xc_step (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          go,
	input  logic [lcg_xc_pkg::KEY_W-1:0]  x_in,
	input  logic [lcg_xc_pkg::KEY_W-1:0]  multiplier,
	input  logic [lcg_xc_pkg::KEY_W-1:0]  increment,
	input  logic [lcg_xc_pkg::KEY_W-1:0]  modulus,
	output lcg_xc_pkg::step_stat_t        stat,
	output logic [lcg_xc_pkg::KEY_W-1:0]  word
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV
	} state_t;

	state_t                           state_q;
	logic [lcg_xc_pkg::PROD_W-1:0]    acc_q;
	logic [lcg_xc_pkg::PROD_W-1:0]    mcand_q;
	logic [lcg_xc_pkg::KEY_W-1:0]     mplier_q;
	logic [lcg_xc_pkg::KEY_W-1:0]     rem_q;
	logic [lcg_xc_pkg::CNT_W-1:0]     cnt_q;

	logic [lcg_xc_pkg::DIV_W-1:0]     divisor;
	logic [lcg_xc_pkg::ALU_W-1:0]     op_a;
	logic [lcg_xc_pkg::ALU_W-1:0]     op_b;
	logic                             sub;
	logic [lcg_xc_pkg::ALU_W-1:0]     sum;
	logic                             cout;
	logic [lcg_xc_pkg::KEY_W-1:0]     rem_next;
	logic                             mul_last;
	logic                             div_last;

	// modulus zero reduces by 2^31
	assign divisor = {(modulus == '0), modulus};

	always_comb begin
		op_a = '0;
		op_b = '0;
		sub  = 1'b0;
		case (state_q)
			ST_MUL: begin
				op_a = {1'b0, acc_q};
				op_b = {1'b0, mcand_q};
			end
			ST_DIV: begin
				op_a = {{(lcg_xc_pkg::ALU_W - lcg_xc_pkg::KEY_W - 1){1'b0}},
					rem_q, acc_q[lcg_xc_pkg::PROD_W-1]};
				op_b = {{(lcg_xc_pkg::ALU_W - lcg_xc_pkg::DIV_W){1'b0}}, divisor};
				sub  = 1'b1;
			end
			default: begin
			end
		endcase
	end

	lcg_xc_addsub u_addsub (
		.op_a (op_a),
		.op_b (op_b),
		.sub  (sub),
		.sum  (sum),
		.cout (cout)
	);

	// no borrow: trial remainder fits, keep the difference
	assign rem_next = cout ? sum[lcg_xc_pkg::KEY_W-1:0]
		: {rem_q[lcg_xc_pkg::KEY_W-2:0], acc_q[lcg_xc_pkg::PROD_W-1]};

	assign mul_last = (cnt_q == lcg_xc_pkg::CNT_W'(lcg_xc_pkg::MUL_STEPS - 1));
	assign div_last = (cnt_q == lcg_xc_pkg::CNT_W'(lcg_xc_pkg::DIV_STEPS - 1));

	assign word = rem_next;
	assign stat = '{busy: (state_q != ST_IDLE), done: ((state_q == ST_DIV) && div_last)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			acc_q    <= '0;
			mcand_q  <= '0;
			mplier_q <= '0;
			rem_q    <= '0;
			cnt_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (go) begin
						acc_q    <= {{(lcg_xc_pkg::PROD_W - lcg_xc_pkg::KEY_W){1'b0}},
							increment};
						mcand_q  <= {{(lcg_xc_pkg::PROD_W - lcg_xc_pkg::KEY_W){1'b0}},
							multiplier};
						mplier_q <= x_in;
						cnt_q    <= '0;
						state_q  <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mplier_q[0])
						acc_q <= sum[lcg_xc_pkg::PROD_W-1:0];
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					if (mul_last) begin
						cnt_q   <= '0;
						rem_q   <= '0;
						state_q <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DIV: begin
					rem_q <= rem_next;
					acc_q <= acc_q << 1;
					if (div_last) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: hdl/lcg_keystream_xor_cipher_top.sv
// Output: each result is registered, shown in the cycle after its input.
// Throughput: bytes that do not close a keystream word go at one per cycle
// while results are taken downstream; the byte that closes a word starts
// the next-word unit, which holds ready low while it runs 31 multiply steps
// and then 62 remainder steps on one adder.
// Reset: registers take their defaults, keystream restarts at word 0, byte 0.
module lcg_keystream_xor_cipher_top #(
	parameter int WORD_BYTES = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// input byte channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  lcg_xc_pkg::in_item_t               in_data,
	// result channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output lcg_xc_pkg::out_item_t              out_data,
	// configuration writes
	input  logic                               cfg_we,
	input  logic [lcg_xc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lcg_xc_pkg::KEY_W-1:0]       cfg_wdata
);

	localparam int POS_W = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;

	// configuration registers
	logic [lcg_xc_pkg::KEY_W-1:0] mult_q;
	logic [lcg_xc_pkg::KEY_W-1:0] incr_q;
	logic [lcg_xc_pkg::KEY_W-1:0] mod_q;
	logic [lcg_xc_pkg::KEY_W-1:0] seed_q;

	// keystream state
	logic [lcg_xc_pkg::KEY_W-1:0] key_q;
	logic [POS_W-1:0]             pos_q;

	// output register
	logic                         out_valid_q;
	lcg_xc_pkg::out_item_t        out_q;

	logic                         in_xfer;
	logic [lcg_xc_pkg::KEY_W-1:0] cur_key;
	logic [POS_W-1:0]             cur_pos;
	logic                         wrap;
	logic [7:0]                   kbyte;
	lcg_xc_pkg::step_stat_t       step_stat;
	logic [lcg_xc_pkg::KEY_W-1:0] step_word;

	// Ready drops while the next word is being worked out, and while a
	// result is still waiting downstream with no take this cycle.
	assign in_ready = !step_stat.busy && (!out_valid_q || out_ready);
	assign in_xfer  = in_valid && in_ready;

	// Start of message reloads the seed (unreduced) at byte zero.
	assign cur_key = in_data.start_of_message ? seed_q : key_q;
	assign cur_pos = in_data.start_of_message ? '0 : pos_q;
	assign wrap    = (cur_pos == POS_W'(WORD_BYTES - 1));

	// Little-endian byte pick; positions past the fourth shift out to zero.
	assign kbyte = 8'({1'b0, cur_key} >> {cur_pos, 3'b000});

	lcg_xc_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (in_xfer && wrap),
		.x_in       (cur_key),
		.multiplier (mult_q),
		.increment  (incr_q),
		.modulus    (mod_q),
		.stat       (step_stat),
		.word       (step_word)
	);

	// Configuration port: out-of-range indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mult_q <= lcg_xc_pkg::KEY_W'(1);
			incr_q <= '0;
			mod_q  <= lcg_xc_pkg::KEY_W'(2147483647);
			seed_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lcg_xc_pkg::REG_MULTIPLIER: mult_q <= cfg_wdata;
				lcg_xc_pkg::REG_INCREMENT:  incr_q <= cfg_wdata;
				lcg_xc_pkg::REG_MODULUS:    mod_q  <= cfg_wdata;
				lcg_xc_pkg::REG_SEED_VALUE: seed_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Keystream state. The unit returns the new word on the edge it
	// finishes, so the word is in place before ready rises again.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
			pos_q <= '0;
		end else begin
			if (step_stat.done)
				key_q <= step_word;
			else if (in_xfer)
				key_q <= cur_key;
			if (in_xfer)
				pos_q <= wrap ? '0 : cur_pos + 1'b1;
		end
	end

	// Output register: holds a result until the downstream transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_q.cipher_byte    <= in_data.plain_byte ^ kbyte;
			out_q.end_of_message <= in_data.last_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: hdl/lcg_xc_chk.sv
module lcg_xc_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_ready,
	input lcg_xc_pkg::in_item_t               in_data,
	input logic                               out_valid,
	input logic                               out_ready,
	input lcg_xc_pkg::out_item_t              out_data
);

	// every input transaction shows its result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after input transaction");

	// the end flag is carried straight through
	a_end_flag: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_data.end_of_message == $past(in_data.last_byte))
		else $error("end_of_message does not match last_byte");

	// a stalled result blocks new input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while result stalled");

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("stalled result changed");

endmodule

bind lcg_keystream_xor_cipher_top lcg_xc_chk u_lcg_xc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

// File: verif/lcg_keystream_xor_cipher_checker.sv
module lcg_keystream_xor_cipher_checker
	import lcg_xc_pkg::*;
#(
	parameter int WORD_BYTES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_data,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_data,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [KEY_W-1:0]     cfg_wdata,
	output int                   fail_count,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_REPORTS = 40;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;

	// shadow registers and keystream state
	logic [KEY_W-1:0] lcg_mult;
	logic [KEY_W-1:0] lcg_incr;
	logic [KEY_W-1:0] lcg_mod;
	logic [KEY_W-1:0] lcg_seed;
	logic [KEY_W-1:0] key_word;
	int unsigned      byte_pos;

	out_item_t cipher_q[$];
	int        errors = 0;

	// modulus zero stands for 2^31
	function automatic logic [KEY_W-1:0] next_key(input logic [KEY_W-1:0] prev);
		logic [63:0] sum;
		sum = 64'(lcg_mult) * 64'(prev) + 64'(lcg_incr);
		if (lcg_mod == '0)
			return sum[KEY_W-1:0];
		return KEY_W'(sum % 64'(lcg_mod));
	endfunction

	function automatic out_item_t encipher(input in_item_t it);
		out_item_t  res;
		logic [7:0] pad;
		if (it.start_of_message) begin
			key_word = lcg_seed;
			byte_pos = 0;
		end
		if (byte_pos >= WORD_BYTES || byte_pos >= 8)
			byte_pos = 0;
		// bytes above the top of a 31-bit word come out as zero
		pad = 8'(64'(key_word) >> (8 * byte_pos));
		res.cipher_byte    = it.plain_byte ^ pad;
		res.end_of_message = it.last_byte;
		byte_pos++;
		if (byte_pos >= WORD_BYTES) begin
			byte_pos = 0;
			key_word = next_key(key_word);
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			lcg_mult = KEY_W'(1);
			lcg_incr = '0;
			lcg_mod  = KEY_MAX;
			lcg_seed = '0;
			key_word = '0;
			byte_pos = 0;
			cipher_q.delete();
			pending    <= 0;
			fail_count <= errors;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_MULTIPLIER: lcg_mult = cfg_wdata;
					REG_INCREMENT:  lcg_incr = cfg_wdata;
					REG_MODULUS:    lcg_mod  = cfg_wdata;
					REG_SEED_VALUE: lcg_seed = cfg_wdata;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected transaction, expected none, actual %02h/%b",
							$time, out_data.cipher_byte, out_data.end_of_message);
				end else begin
					want = cipher_q.pop_front();
					if (out_data.cipher_byte !== want.cipher_byte) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: cipher_byte expected %02h actual %02h",
								$time, want.cipher_byte, out_data.cipher_byte);
					end
					if (out_data.end_of_message !== want.end_of_message) begin
						errors++;
						if (errors <= MAX_REPORTS)
							$display("%0t: end_of_message expected %b actual %b",
								$time, want.end_of_message, out_data.end_of_message);
					end
				end
			end
			if (in_valid && in_ready)
				cipher_q.insert(cipher_q.size(), encipher(in_data));
			pending    <= cipher_q.size();
			fail_count <= errors;
		end
	end

endmodule

// File: verif/lcg_keystream_xor_cipher_top_tb.sv
module lcg_keystream_xor_cipher_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lcg_xc_pkg::*;

	localparam int WORD_BYTES   = 4;
	localparam logic [KEY_W-1:0] KEY_MAX = '1;
	localparam int RANDOM_ITEMS = 930;    // random byte transactions after the directed part
	localparam int PHASE_ITEMS  = 110;    // target bytes per register setting, rounded up to whole messages
	// after a word closes, the next-word unit keeps working well past the
	// last result, so register writes wait this long
	localparam int BUSY_CYCLES  = 120;
	localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
	localparam int CYCLE_LIMIT  = 1_000_000;
	// indexes above the last register must be ignored by the block
	localparam int SPARE_IDX_LO = int'(REG_SEED_VALUE) + 1;
	localparam int SPARE_IDX_HI = (1 << CFG_IDX_W) - 1;

	typedef enum int {RX_EAGER, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_pattern_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_item_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_item_t            out_data;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [KEY_W-1:0]     cfg_wdata = '0;

	int fail_count;
	int pending;
	int cycle_count   = 0;
	int hold_requests = 0;    // bumped by the stimulus, served by the receiver
	int burst_left    = 0;    // bytes left in the current sender burst
	bit no_gaps       = 1'b0; // sender offers back to back while set

	lcg_keystream_xor_cipher_top #(
		.WORD_BYTES(WORD_BYTES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	// watches both channels and the register port, predicts and compares
	lcg_keystream_xor_cipher_checker #(
		.WORD_BYTES(WORD_BYTES)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog: a hung handshake ends the run here
	initial begin
		wait (cycle_count == CYCLE_LIMIT);
		$display("lcg_keystream_xor_cipher_top verification failed");
		$finish;
	end

	// Receiver: ready follows a pattern that is picked anew at random in the run, so
	// stalls land on both the one-per-cycle bytes and the word boundaries.
	// A hold-off request drops ready for a long stretch so the output
	// register fills and the block has to push back on the input side.
	initial begin
		int          holds_served;
		int          rx_cycle;
		rx_pattern_t rx_mode;
		holds_served = 0;
		rx_cycle     = 0;
		rx_mode      = RX_EAGER;
		forever begin
			@(posedge clk);
			if (hold_requests != holds_served) begin
				holds_served = hold_requests;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (rx_cycle % 256 == 0)
					rx_mode = rx_pattern_t'($urandom_range(3, 0));
				case (rx_mode)
					RX_EAGER:    out_ready <= 1'b1;
					RX_MOSTLY:   out_ready <= ($urandom_range(3, 0) != 0);
					RX_SPARSE:   out_ready <= ($urandom_range(3, 0) == 0);
					RX_PERIODIC: out_ready <= (rx_cycle % 5 != 0);
					default:     out_ready <= 1'b1;
				endcase
				rx_cycle++;
			end
		end
	end

	// One byte transaction. The sender works in bursts; a gap is only taken
	// before the burst's first byte. Valid is left high after acceptance so
	// that a back-to-back byte never lowers and raises it in one step.
	task automatic push_byte(input logic [7:0] b, input logic s, input logic l);
		int gap;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(32, 1);
			if (!no_gaps)
				gap = $urandom_range(15, 1);
		end
		burst_left--;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{plain_byte: b, start_of_message: s, last_byte: l};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// wait until every predicted byte is back and the next-word unit is idle
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (BUSY_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [KEY_W-1:0] mult, input logic [KEY_W-1:0] incr,
		input logic [KEY_W-1:0] modulus, input logic [KEY_W-1:0] seed, input bit spare);
		write_reg(REG_MULTIPLIER, mult);
		write_reg(REG_INCREMENT, incr);
		write_reg(REG_MODULUS, modulus);
		write_reg(REG_SEED_VALUE, seed);
		if (spare)
			write_reg(CFG_IDX_W'($urandom_range(SPARE_IDX_HI, SPARE_IDX_LO)), KEY_W'($urandom));
		cfg_we <= 1'b0;
	endtask

	// extremes weighted heavily, the rest uniform over 31 bits
	function automatic logic [KEY_W-1:0] pick_word();
		case ($urandom_range(7, 0))
			0:       return '0;
			1:       return KEY_W'(1);
			2:       return KEY_MAX;
			default: return KEY_W'($urandom);
		endcase
	endfunction

	function automatic logic [KEY_W-1:0] pick_modulus();
		case ($urandom_range(7, 0))
			0:       return '0;    // taken as 2^31
			1:       return KEY_W'(1);
			2:       return KEY_W'($urandom_range(1000, 2));
			3:       return KEY_MAX;
			default: return KEY_W'($urandom);
		endcase
	endfunction

	// Mostly a well-formed message: start on the first byte, last on the
	// final one. Some open without a start and carry on the keystream, and
	// a few flags are scattered mid-message as noise.
	task automatic send_message(input int len, input bit with_start);
		logic s;
		logic l;
		for (int k = 0; k < len; k++) begin
			s = (k == 0 && with_start) || ($urandom_range(24, 0) == 0);
			l = (k == len - 1) || ($urandom_range(24, 0) == 0);
			push_byte(8'($urandom_range(255, 0)), s, l);
		end
	endtask

	initial begin
		int sent;
		int phase;
		int phase_sent;
		int len;
		sent  = 0;
		phase = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part ---
		// no start after reset: keystream runs from word zero on the reset settings
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'hFF, 1'b0, 1'b0);
		push_byte(8'h5A, 1'b0, 1'b1);

		// every register at its top value; seed equal to the modulus is not reduced
		settle();
		load_settings(KEY_MAX, KEY_MAX, KEY_MAX, KEY_MAX, 1'b1);
		push_byte(8'hFF, 1'b1, 1'b0);
		push_byte(8'h00, 1'b0, 1'b0);
		push_byte(8'h81, 1'b0, 1'b0);
		push_byte(8'h7E, 1'b0, 1'b0);
		push_byte(8'hC3, 1'b0, 1'b0);
		push_byte(8'h3C, 1'b0, 1'b1);
		// carries on after a last byte with no start, then restarts mid-word
		push_byte(8'h11, 1'b0, 1'b0);
		push_byte(8'h55, 1'b1, 1'b1);

		// modulus zero: next word is the sum taken modulo 2^31
		settle();
		load_settings(pick_word(), KEY_MAX, '0, KEY_W'($urandom), 1'b0);
		send_message(8, 1'b1);

		// modulus one with zero multiplier: seed first, then zero words
		settle();
		load_settings('0, '0, KEY_W'(1), KEY_MAX, 1'b0);
		send_message(5, 1'b1);

		// --- random part: a fresh register setting every phase ---
		while (sent < RANDOM_ITEMS) begin
			settle();
			load_settings(pick_word(), pick_word(), pick_modulus(), pick_word(),
				$urandom_range(2, 0) == 0);
			no_gaps    = (phase % 4 == 3);
			burst_left = 0;
			phase_sent = 0;
			while (phase_sent < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
				// receiver goes quiet while the sender keeps offering
				if (phase == 2 && phase_sent == 0)
					hold_requests++;
				len = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 25)
					: $urandom_range(24, 1);
				send_message(len, $urandom_range(7, 0) != 0);
				phase_sent += len;
				sent       += len;
			end
			phase++;
		end

		settle();
		if (fail_count == 0 && pending == 0) begin
			$display("lcg_keystream_xor_cipher_top verification clean");
		end else begin
			$display("lcg_keystream_xor_cipher_top verification failed");
		end
		$finish;
	end

endmodule

// File: files.f
hdl/lcg_xc_pkg.sv
hdl/lcg_xc_addsub.sv
hdl/lcg_xc_step.sv
hdl/lcg_keystream_xor_cipher_top.sv
hdl/lcg_xc_chk.sv
verif/lcg_keystream_xor_cipher_checker.sv
verif/lcg_keystream_xor_cipher_top_tb.sv
